// File: hw/rtl/osa_pkg.sv
// Shared widths, register indexes, class codes and types for the subcarrier allocator.
package osa_pkg;

	localparam int IDX_W     = 14;
	localparam int FFT_W     = 15;
	localparam int DENS_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 21;
	localparam int H_W       = 14;
	localparam int CMP_W     = 17;

	localparam int MAX_SUBCARRIERS_DEF = 16384;
	localparam int RST_FFT_SIZE        = 1024;
	localparam int RST_GUARD_DENSITY   = 25;

	// Guard count is floor(n*density/200): divide by 8 with a shift, then by 25.
	localparam int GUARD_DIV   = 200;
	localparam int DIV_SHIFT   = 3;
	localparam int DIV_REST    = GUARD_DIV >> DIV_SHIFT;
	localparam int Y_W         = PROD_W - DIV_SHIFT;
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP_W     = 13;
	localparam int RECIP_REST  = ((1 << RECIP_SHIFT) + DIV_REST - 1) / DIV_REST;

	localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GUARD_DENSITY = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CLS_ZERO  = 2'd0,
		CLS_PILOT = 2'd1,
		CLS_DATA  = 2'd2
	} bin_class_t;

	typedef struct packed {
		logic [FFT_W-1:0] fft_n;
		logic [H_W-1:0]   zero_half;
	} osa_cfg_t;

	typedef struct packed {
		logic first;
		logic last;
		logic dc_lo;
		logic dc_hi;
		logic pil_dc;
		logic lower;
		logic odd;
	} osa_flags_t;

endpackage

// File: hw/rtl/osa_cfg.sv
// Configuration registers and the pipelined zero half-count derivation.
module osa_cfg #(
	parameter int MAX_SUBCARRIERS = osa_pkg::MAX_SUBCARRIERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [osa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [osa_pkg::FFT_W-1:0]      cfg_data,
	output osa_pkg::osa_cfg_t              cfg
);
	import osa_pkg::*;

	localparam int RST_N    = (RST_FFT_SIZE > MAX_SUBCARRIERS) ? MAX_SUBCARRIERS : RST_FFT_SIZE;
	localparam int RST_PROD = RST_N * RST_GUARD_DENSITY;
	localparam int RST_Y    = RST_PROD >> DIV_SHIFT;
	localparam int RST_QEST = (RST_Y * RECIP_REST) >> RECIP_SHIFT;
	localparam int RST_H    = RST_PROD / GUARD_DIV + 1;

	localparam logic [FFT_W-1:0] MAX_N = FFT_W'(MAX_SUBCARRIERS);

	logic                     fft_wr;
	logic                     dens_wr;
	logic [FFT_W-1:0]         wr_n;
	logic [FFT_W-1:0]         mul_n;
	logic [DENS_W-1:0]        mul_d;
	logic [Y_W-1:0]           y_c;
	logic [Y_W+RECIP_W-1:0]   recip_prod;
	logic [Y_W:0]             back_mul;

	logic [FFT_W-1:0]         n_q;
	logic [DENS_W-1:0]        dens_q;
	logic [PROD_W-1:0]        prod_q;
	logic [H_W-1:0]           qest_q;
	logic [H_W-1:0]           h_q;

	assign fft_wr  = cfg_wen && (cfg_index == REG_FFT_SIZE);
	assign dens_wr = cfg_wen && (cfg_index == REG_GUARD_DENSITY);
	assign wr_n    = (cfg_data > MAX_N) ? MAX_N : cfg_data;
	// Multiply with the value being written, the other operand from its register.
	assign mul_n   = fft_wr ? wr_n : n_q;
	assign mul_d   = dens_wr ? cfg_data[DENS_W-1:0] : dens_q;

	assign y_c        = prod_q[PROD_W-1:DIV_SHIFT];
	assign recip_prod = (Y_W+RECIP_W)'(y_c) * (Y_W+RECIP_W)'(RECIP_REST);
	assign back_mul   = (Y_W+1)'(qest_q) * (Y_W+1)'(DIV_REST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= FFT_W'(RST_N);
			dens_q <= DENS_W'(RST_GUARD_DENSITY);
			prod_q <= PROD_W'(RST_PROD);
			qest_q <= H_W'(RST_QEST);
			h_q    <= H_W'(RST_H);
		end else begin
			if (fft_wr) begin
				n_q <= wr_n;
			end
			if (dens_wr) begin
				dens_q <= cfg_data[DENS_W-1:0];
			end
			if (fft_wr || dens_wr) begin
				prod_q <= PROD_W'(mul_n) * PROD_W'(mul_d);
			end
			// Estimate is exact or one high; correct with one compare.
			qest_q <= recip_prod[RECIP_SHIFT +: H_W];
			h_q    <= ((Y_W+1)'(y_c) < back_mul) ? qest_q : qest_q + 1'b1;
		end
	end

	assign cfg.fft_n     = n_q;
	assign cfg.zero_half = h_q;

endmodule

// File: hw/rtl/osa_classify.sv
// Two-stage bin classifier with running pilot and data tallies and an output register.
module osa_classify (
	input  logic                       clk,
	input  logic                       arst_n,
	input  osa_pkg::osa_cfg_t          cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [osa_pkg::IDX_W-1:0]  bin_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 bin_class,
	output logic [osa_pkg::IDX_W-1:0]  list_slot,
	output logic                       final_bin
);
	import osa_pkg::*;

	localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1);
	localparam logic signed [CMP_W-1:0] TWO = CMP_W'(2);

	logic                      vld_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      vld_s2;
	logic [IDX_W-1:0]          idx_s2;
	osa_flags_t                flg_s2;
	logic                      out_vld_q;
	bin_class_t                cls_q;
	logic [IDX_W-1:0]          slot_q;
	logic                      last_q;
	logic [IDX_W-1:0]          pilot_q;
	logic [IDX_W-1:0]          data_q;

	logic                      out_load;
	logic                      s2_load;
	logic signed [CMP_W-1:0]   n_c;
	logic signed [CMP_W-1:0]   half_c;
	logic signed [CMP_W-1:0]   h_c;
	logic signed [CMP_W-1:0]   i1;
	logic signed [CMP_W-1:0]   i2;
	osa_flags_t                flg_c;
	logic                      lo_guard;
	logic                      up_guard;
	logic                      edge_pil;
	logic [IDX_W-1:0]          base_p;
	logic [IDX_W-1:0]          base_d;
	bin_class_t                cls_c;
	logic [IDX_W-1:0]          slot_c;

	assign out_load = vld_s2 && (!out_vld_q || out_ready);
	assign s2_load  = vld_s1 && (!vld_s2 || out_load);
	assign in_ready = !vld_s1 || s2_load;

	assign n_c    = signed'({2'b0, cfg.fft_n});
	assign half_c = signed'({3'b0, cfg.fft_n[FFT_W-1:1]});
	assign h_c    = signed'({3'b0, cfg.zero_half});
	assign i1     = signed'({3'b0, idx_s1});
	assign i2     = signed'({3'b0, idx_s2});

	// Stage one: tests that need only the symbol size.
	always_comb begin
		flg_c.first  = (idx_s1 == '0);
		flg_c.last   = (i1 == n_c - ONE);
		flg_c.dc_lo  = (i1 == half_c - ONE);
		flg_c.dc_hi  = (i1 == half_c);
		flg_c.pil_dc = (i1 == half_c - TWO);
		flg_c.lower  = (i1 < half_c);
		flg_c.odd    = idx_s1[0];
	end

	// Stage two: guard bands, then rule order, then tallies.
	assign lo_guard = (i2 < h_c - ONE);
	assign up_guard = (i2 >= n_c - h_c + ONE);
	assign edge_pil = (i2 == n_c - h_c);
	assign base_p   = flg_s2.first ? '0 : pilot_q;
	assign base_d   = flg_s2.first ? '0 : data_q;

	always_comb begin
		cls_c  = CLS_ZERO;
		slot_c = idx_s2;
		if (lo_guard) begin
			cls_c  = CLS_ZERO;
			slot_c = idx_s2;
		end else if (flg_s2.dc_lo) begin
			cls_c  = CLS_ZERO;
			slot_c = cfg.zero_half - 1'b1;
		end else if (flg_s2.dc_hi) begin
			cls_c  = CLS_ZERO;
			slot_c = cfg.zero_half;
		end else if (up_guard) begin
			cls_c  = CLS_ZERO;
			slot_c = idx_s2 + {cfg.zero_half[H_W-2:0], 1'b0} - cfg.fft_n[IDX_W-1:0];
		end else if (flg_s2.pil_dc || edge_pil) begin
			cls_c = CLS_PILOT;
		end else if (flg_s2.lower) begin
			// Lower half parity follows the guard width: pilots where parity differs from h odd.
			cls_c = (flg_s2.odd != cfg.zero_half[0]) ? CLS_PILOT : CLS_DATA;
		end else begin
			cls_c = flg_s2.odd ? CLS_PILOT : CLS_DATA;
		end
		if (cls_c == CLS_PILOT) begin
			slot_c = base_p;
		end else if (cls_c == CLS_DATA) begin
			slot_c = base_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			pilot_q   <= '0;
			data_q    <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (!vld_s2 || out_load) begin
				vld_s2 <= vld_s1;
			end
			if (!out_vld_q || out_ready) begin
				out_vld_q <= vld_s2;
			end
			if (out_load) begin
				pilot_q <= (cls_c == CLS_PILOT) ? base_p + 1'b1 : base_p;
				data_q  <= (cls_c == CLS_DATA) ? base_d + 1'b1 : base_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			idx_s1 <= bin_index;
		end
		if (s2_load) begin
			idx_s2 <= idx_s1;
			flg_s2 <= flg_c;
		end
		if (out_load) begin
			cls_q  <= cls_c;
			slot_q <= slot_c;
			last_q <= flg_s2.last;
		end
	end

	assign out_valid = out_vld_q;
	assign bin_class = cls_q;
	assign list_slot = slot_q;
	assign final_bin = last_q;

endmodule

// File: hw/rtl/ofdm_subcarrier_allocator.sv
// Top level of the OFDM subcarrier allocator: configuration block and classifier pipeline.

// Takes one subcarrier index per clock while the output is not stalled and presents one
// word per index through the input register, the parity and DC test stage and the
// classification and tally stage into the output register, so a full symbol streams at
// one bin per cycle with no gaps. Indexes are expected in order from zero; index zero
// restarts the pilot and data tallies. The guard half-count is derived from fft_size and
// guard_density by a multiply and a reciprocal divide through the product, estimate and
// half-count registers, which the input stages cover: an index may follow a write in the
// next cycle. A stalled output holds up to three words in flight before in_ready drops.
module ofdm_subcarrier_allocator #(
	parameter int MAX_SUBCARRIERS = osa_pkg::MAX_SUBCARRIERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [osa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [osa_pkg::FFT_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [osa_pkg::IDX_W-1:0]      bin_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     bin_class,
	output logic [osa_pkg::IDX_W-1:0]      list_slot,
	output logic                           final_bin
);
	import osa_pkg::*;

	osa_cfg_t cfg;

	osa_cfg #(
		.MAX_SUBCARRIERS (MAX_SUBCARRIERS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	osa_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.bin_index (bin_index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_class (bin_class),
		.list_slot (list_slot),
		.final_bin (final_bin)
	);

`ifndef NO_ASSERTIONS
	// With the output register empty, the pipeline must always be able to take a word.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while output register empty");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bin_class == CLS_ZERO || bin_class == CLS_PILOT ||
			bin_class == CLS_DATA))
		else $error("unknown bin class on output");

	// A full pipeline cannot accept while the output is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !in_ready |=> !in_ready || out_ready || !out_valid)
		else $error("input accepted with pipeline full and output stalled");
`endif

endmodule
